/* hw/rtl/tbgs_pkg.sv */
// Shared types, constants and helpers of the two-body gravity step core.
`default_nettype none
package tbgs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TS_BITS   = 16;
    localparam int WORD_W    = 32;
    localparam int CFG_W     = 20;
    localparam int IDX_W     = 3;
    localparam int ACC_W     = 47;
    localparam int GM_W      = 36;
    localparam int NUM_W     = (GM_W + 2 * FRAC_BITS > ACC_W + FRAC_BITS) ?
                               GM_W + 2 * FRAC_BITS : ACC_W + FRAC_BITS;
    localparam int DEN_W     = 34;
    localparam int DCNT_W    = $clog2(NUM_W + 1);
    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = (FRAC_BITS > TS_BITS) ? FRAC_BITS + 1 : TS_BITS + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int T_W       = 48;
    localparam int SUM_W     = 50;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = 32;
    localparam int HALF_W    = 16;
    localparam int DIST_MIN_RAW = ((1 << FRAC_BITS) + 500) / 1000;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [SUM_W-1:0]  wide_t;
    typedef logic [NUM_W-1:0]         num_t;
    typedef logic [DEN_W-1:0]         den_t;
    typedef logic [DCNT_W-1:0]        dcnt_t;
    typedef logic [MUL_A_W-1:0]       mula_t;
    typedef logic [MUL_B_W-1:0]       mulb_t;
    typedef logic [T_W-1:0]           t_t;
    typedef logic [SQ_W-1:0]          sq_t;
    typedef logic [ACC_W-1:0]         acc_t;
    typedef logic [FRAC_BITS:0]       unit_t;

    localparam den_t  DIST_MIN = (DIST_MIN_RAW < 1) ? den_t'(1) : den_t'(DIST_MIN_RAW);
    localparam acc_t  ACC_CAP  = '1;
    localparam unit_t U_ONE    = unit_t'(1) << FRAC_BITS;
    localparam sq_t   SQ_TOP   = sq_t'(1) << (SQ_W - 2);
    localparam wide_t WORD_MAX = 50'sd2147483647;
    localparam wide_t WORD_MIN = -50'sd2147483648;

    localparam logic [IDX_W-1:0] REG_GRAVITY = 3'd0;
    localparam logic [IDX_W-1:0] REG_MASS_A  = 3'd1;
    localparam logic [IDX_W-1:0] REG_MASS_B  = 3'd2;
    localparam logic [IDX_W-1:0] REG_RAD_A   = 3'd3;
    localparam logic [IDX_W-1:0] REG_RAD_B   = 3'd4;
    localparam logic [IDX_W-1:0] REG_FIELD_W = 3'd5;
    localparam logic [IDX_W-1:0] REG_FIELD_H = 3'd6;

    localparam logic [19:0] RST_GRAVITY = 20'd80000;
    localparam logic [15:0] RST_MASS_A  = 16'd25;
    localparam logic [15:0] RST_MASS_B  = 16'd1000;
    localparam logic [9:0]  RST_RAD_A   = 10'd25;
    localparam logic [9:0]  RST_RAD_B   = 10'd100;
    localparam logic [11:0] RST_FIELD_W = 12'd1920;
    localparam logic [11:0] RST_FIELD_H = 12'd1080;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;
    localparam logic BODY_A  = 1'b0;
    localparam logic BODY_B  = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_OFF, ST_SQ, ST_SQRT_GO, ST_SQRT_W, ST_GM, ST_D1, ST_D1W,
        ST_D2, ST_D2W, ST_UD, ST_UDW, ST_T0, ST_T1, ST_T2, ST_T3, ST_T4,
        ST_WRAP, ST_MOVE, ST_OUT
    } state_t;

    typedef struct packed {
        logic              operation;
        logic              body_select;
        logic signed [31:0] init_pos_x;
        logic signed [31:0] init_pos_y;
        logic signed [31:0] init_vel_x;
        logic signed [31:0] init_vel_y;
        logic [15:0]       time_step;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] report_a_x;
        logic signed [31:0] report_a_y;
        logic signed [31:0] report_a_vx;
        logic signed [31:0] report_a_vy;
        logic signed [31:0] report_b_x;
        logic signed [31:0] report_b_y;
        logic signed [31:0] report_b_vx;
        logic signed [31:0] report_b_vy;
    } out_item_t;

    function automatic word_t sat_word(input wide_t v);
        word_t r;
        if (v > WORD_MAX) begin
            r = word_t'(WORD_MAX);
        end else if (v < WORD_MIN) begin
            r = word_t'(WORD_MIN);
        end else begin
            r = word_t'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/tbgs_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module tbgs_div (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire tbgs_pkg::num_t  num,
    input  wire tbgs_pkg::den_t  den,
    output logic                 done,
    output tbgs_pkg::num_t       quo
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    tbgs_pkg::dcnt_t cnt_reg, cnt_next;
    tbgs_pkg::den_t  rem_reg, rem_next;
    tbgs_pkg::den_t  den_reg, den_next;
    tbgs_pkg::num_t  quo_reg, quo_next;
    logic [tbgs_pkg::DEN_W:0] trial, diff;
    logic            ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[tbgs_pkg::NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        diff      = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = tbgs_pkg::dcnt_t'(tbgs_pkg::NUM_W);
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
        end else if (busy_reg) begin
            rem_next = ge ? diff[tbgs_pkg::DEN_W-1:0] : trial[tbgs_pkg::DEN_W-1:0];
            quo_next = {quo_reg[tbgs_pkg::NUM_W-2:0], ge};
            cnt_next = cnt_reg - tbgs_pkg::dcnt_t'(1);
            if (cnt_reg == tbgs_pkg::dcnt_t'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with empty count");
`endif

endmodule
`default_nettype wire

/* hw/rtl/tbgs_isqrt.sv */
// Digit-by-digit integer square root, one result bit per cycle.
`default_nettype none
module tbgs_isqrt (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire tbgs_pkg::sq_t  radicand,
    output logic                done,
    output logic [tbgs_pkg::ROOT_W-1:0] root
);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    tbgs_pkg::sq_t n_reg, n_next;
    tbgs_pkg::sq_t res_reg, res_next;
    tbgs_pkg::sq_t bit_reg, bit_next;
    tbgs_pkg::sq_t trial;

    always_comb
    begin
        trial     = res_reg + bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            n_next    = radicand;
            res_next  = '0;
            bit_next  = tbgs_pkg::SQ_TOP;
        end else if (busy_reg) begin
            if (n_reg >= trial) begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[tbgs_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

/* hw/rtl/two_body_gravity_step_core.sv */
// Top level of the two-body gravity step core: sequencer, state and shared multiplier.
// Usage:
// Items arrive on item_valid/item_ready/item, one beat per item; results leave on
// result_valid/result_ready/result, one beat per item, holding both bodies' state.
// The user must write registers through wr_en/wr_index/wr_data only while the core is idle; the core does not check.
// A load beat overwrites one body and its result is valid in the cycle after acceptance.
// A step beat runs two pulls and four position updates on one shared multiplier,
// one bit-serial square root unit (run once per pull) and one bit-serial divider
// (eight quotients per step); the divider takes most of the time of a step.
// One item is in flight at a time: item_ready is high only while the core is idle,
// so no new item is taken until the result of the last one has been accepted.
// When the receiver stalls, the result holds on result and no new item is taken.
// Reset clears both bodies to zero, loads the register defaults and leaves the
// core idle and ready.
`default_nettype none
module two_body_gravity_step_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire tbgs_pkg::in_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output tbgs_pkg::out_item_t      result,
    input  wire logic                wr_en,
    input  wire logic [tbgs_pkg::IDX_W-1:0] wr_index,
    input  wire logic [tbgs_pkg::CFG_W-1:0] wr_data
);

    tbgs_pkg::state_t state_reg, state_next;

    logic [19:0] grav_reg, grav_next;
    logic [15:0] mass_a_reg, mass_a_next, mass_b_reg, mass_b_next;
    logic [9:0]  rad_a_reg, rad_a_next, rad_b_reg, rad_b_next;
    logic [11:0] fw_reg, fw_next, fh_reg, fh_next;

    tbgs_pkg::word_t apx_reg, apx_next, apy_reg, apy_next;
    tbgs_pkg::word_t avx_reg, avx_next, avy_reg, avy_next;
    tbgs_pkg::word_t bpx_reg, bpx_next, bpy_reg, bpy_next;
    tbgs_pkg::word_t bvx_reg, bvx_next, bvy_reg, bvy_next;

    logic        body_reg, body_next;
    logic        axis_reg, axis_next;
    logic [1:0]  crd_reg, crd_next;
    logic [2:0]  sq_cnt_reg, sq_cnt_next;
    logic [15:0] dt_reg, dt_next;
    logic [32:0] offx_reg, offx_next, offy_reg, offy_next;
    logic        negx_reg, negx_next, negy_reg, negy_next;
    logic [1:0]  sh_reg, sh_next;
    logic [30:0] bx_reg, bx_next, by_reg, by_next;
    tbgs_pkg::sq_t   sumsq_reg, sumsq_next;
    logic [tbgs_pkg::PROD_W-1:0] prod_reg, prod_next;
    tbgs_pkg::den_t  d_reg, d_next;
    tbgs_pkg::acc_t  acc_reg, acc_next;
    tbgs_pkg::unit_t u_reg, u_next;
    tbgs_pkg::t_t    t_reg, t_next;
    tbgs_pkg::word_t pw_reg, pw_next;

    tbgs_pkg::mula_t mul_a;
    tbgs_pkg::mulb_t mul_b;

    tbgs_pkg::word_t sx, sy, ox, oy, cur_v, p_c, v_c;
    logic [32:0] dx, dy, magx, magy, vext, vmag, off_sel;
    logic [1:0]  sh_c;
    logic [32:0] bxw, byw;
    logic [15:0] mass_other;
    logic        neg_sel;
    logic [11:0] edge_c;
    logic [9:0]  rad_c;
    tbgs_pkg::wide_t pe, lim, rr, w1, w2, mag_w, dv_w;
    tbgs_pkg::word_t new_v, new_p;
    tbgs_pkg::den_t  d_raw;

    logic            div_start, div_done;
    tbgs_pkg::num_t  div_num, div_quo;
    tbgs_pkg::acc_t  quo_cap;
    logic            sq_start, sq_done;
    logic [tbgs_pkg::ROOT_W-1:0] sq_root;

    tbgs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (d_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    tbgs_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sumsq_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb
    begin
        sx = (body_reg == tbgs_pkg::BODY_B) ? bpx_reg : apx_reg;
        sy = (body_reg == tbgs_pkg::BODY_B) ? bpy_reg : apy_reg;
        ox = (body_reg == tbgs_pkg::BODY_B) ? apx_reg : bpx_reg;
        oy = (body_reg == tbgs_pkg::BODY_B) ? apy_reg : bpy_reg;
        mass_other = (body_reg == tbgs_pkg::BODY_B) ? mass_a_reg : mass_b_reg;
        dx   = {ox[31], ox} - {sx[31], sx};
        dy   = {oy[31], oy} - {sy[31], sy};
        magx = dx[32] ? (33'd0 - dx) : dx;
        magy = dy[32] ? (33'd0 - dy) : dy;
        if (magx[32] || magy[32]) begin
            sh_c = 2'd2;
        end else if (magx[31] || magy[31]) begin
            sh_c = 2'd1;
        end else begin
            sh_c = 2'd0;
        end
        bxw = magx >> sh_c;
        byw = magy >> sh_c;

        if (body_reg == tbgs_pkg::BODY_B) begin
            cur_v = axis_reg ? bvy_reg : bvx_reg;
        end else begin
            cur_v = axis_reg ? avy_reg : avx_reg;
        end
        off_sel = axis_reg ? offy_reg : offx_reg;
        neg_sel = axis_reg ? negy_reg : negx_reg;
        dv_w    = tbgs_pkg::wide_t'(prod_reg[tbgs_pkg::PROD_W-1:tbgs_pkg::TS_BITS]);
        new_v   = tbgs_pkg::sat_word(neg_sel ? tbgs_pkg::wide_t'(cur_v) - dv_w
                                             : tbgs_pkg::wide_t'(cur_v) + dv_w);

        case (crd_reg)
            2'd0:    begin p_c = apx_reg; v_c = avx_reg; end
            2'd1:    begin p_c = apy_reg; v_c = avy_reg; end
            2'd2:    begin p_c = bpx_reg; v_c = bvx_reg; end
            default: begin p_c = bpy_reg; v_c = bvy_reg; end
        endcase
        edge_c = crd_reg[0] ? fh_reg : fw_reg;
        rad_c  = crd_reg[1] ? rad_b_reg : rad_a_reg;
        vext   = {v_c[31], v_c};
        vmag   = v_c[31] ? (33'd0 - vext) : vext;
        pe     = tbgs_pkg::wide_t'(p_c);
        lim    = tbgs_pkg::wide_t'(edge_c) <<< tbgs_pkg::FRAC_BITS;
        rr     = tbgs_pkg::wide_t'(rad_c) <<< tbgs_pkg::FRAC_BITS;
        w1     = (pe < -rr) ? tbgs_pkg::wide_t'(tbgs_pkg::sat_word(lim + rr)) : pe;
        w2     = (w1 > lim + rr) ? tbgs_pkg::wide_t'(tbgs_pkg::sat_word(-rr)) : w1;
        mag_w  = tbgs_pkg::wide_t'(prod_reg[tbgs_pkg::PROD_W-1:tbgs_pkg::TS_BITS]);
        new_p  = tbgs_pkg::sat_word(v_c[31] ? tbgs_pkg::wide_t'(pw_reg) - mag_w
                                            : tbgs_pkg::wide_t'(pw_reg) + mag_w);

        d_raw   = tbgs_pkg::den_t'(sq_root) << sh_reg;
        quo_cap = (div_quo > tbgs_pkg::num_t'(tbgs_pkg::ACC_CAP)) ? tbgs_pkg::ACC_CAP
                  : tbgs_pkg::acc_t'(div_quo);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            tbgs_pkg::ST_SQ: begin
                mul_a = tbgs_pkg::mula_t'(sq_cnt_reg[1] ? by_reg : bx_reg);
                if (sq_cnt_reg[1]) begin
                    mul_b = sq_cnt_reg[0] ? tbgs_pkg::mulb_t'(by_reg[30:tbgs_pkg::HALF_W])
                                          : tbgs_pkg::mulb_t'(by_reg[tbgs_pkg::HALF_W-1:0]);
                end else begin
                    mul_b = sq_cnt_reg[0] ? tbgs_pkg::mulb_t'(bx_reg[30:tbgs_pkg::HALF_W])
                                          : tbgs_pkg::mulb_t'(bx_reg[tbgs_pkg::HALF_W-1:0]);
                end
            end
            tbgs_pkg::ST_GM: begin
                mul_a = tbgs_pkg::mula_t'(grav_reg);
                mul_b = tbgs_pkg::mulb_t'(mass_other);
            end
            tbgs_pkg::ST_T0: begin
                mul_a = tbgs_pkg::mula_t'(acc_reg >> tbgs_pkg::FRAC_BITS);
                mul_b = tbgs_pkg::mulb_t'(u_reg);
            end
            tbgs_pkg::ST_T1: begin
                mul_a = tbgs_pkg::mula_t'(acc_reg[tbgs_pkg::FRAC_BITS-1:0]);
                mul_b = tbgs_pkg::mulb_t'(u_reg);
            end
            tbgs_pkg::ST_T3: begin
                mul_a = tbgs_pkg::mula_t'(t_reg);
                mul_b = tbgs_pkg::mulb_t'(dt_reg);
            end
            tbgs_pkg::ST_WRAP: begin
                mul_a = tbgs_pkg::mula_t'(vmag[31:0]);
                mul_b = tbgs_pkg::mulb_t'(dt_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        state_next  = state_reg;
        grav_next   = grav_reg;
        mass_a_next = mass_a_reg;
        mass_b_next = mass_b_reg;
        rad_a_next  = rad_a_reg;
        rad_b_next  = rad_b_reg;
        fw_next     = fw_reg;
        fh_next     = fh_reg;
        apx_next = apx_reg; apy_next = apy_reg; avx_next = avx_reg; avy_next = avy_reg;
        bpx_next = bpx_reg; bpy_next = bpy_reg; bvx_next = bvx_reg; bvy_next = bvy_reg;
        body_next   = body_reg;
        axis_next   = axis_reg;
        crd_next    = crd_reg;
        sq_cnt_next = sq_cnt_reg;
        dt_next     = dt_reg;
        offx_next   = offx_reg;
        offy_next   = offy_reg;
        negx_next   = negx_reg;
        negy_next   = negy_reg;
        sh_next     = sh_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        sumsq_next  = sumsq_reg;
        d_next      = d_reg;
        acc_next    = acc_reg;
        u_next      = u_reg;
        t_next      = t_reg;
        pw_next     = pw_reg;
        item_ready   = 1'b0;
        result_valid = 1'b0;
        div_start    = 1'b0;
        div_num      = '0;
        sq_start     = 1'b0;

        if (wr_en) begin
            case (wr_index)
                tbgs_pkg::REG_GRAVITY: grav_next   = wr_data[19:0];
                tbgs_pkg::REG_MASS_A:  mass_a_next = wr_data[15:0];
                tbgs_pkg::REG_MASS_B:  mass_b_next = wr_data[15:0];
                tbgs_pkg::REG_RAD_A:   rad_a_next  = wr_data[9:0];
                tbgs_pkg::REG_RAD_B:   rad_b_next  = wr_data[9:0];
                tbgs_pkg::REG_FIELD_W: fw_next     = wr_data[11:0];
                tbgs_pkg::REG_FIELD_H: fh_next     = wr_data[11:0];
                default: ;
            endcase
        end

        case (state_reg)
            tbgs_pkg::ST_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    if (item.operation == tbgs_pkg::OP_LOAD) begin
                        if (item.body_select == tbgs_pkg::BODY_A) begin
                            apx_next = item.init_pos_x;
                            apy_next = item.init_pos_y;
                            avx_next = item.init_vel_x;
                            avy_next = item.init_vel_y;
                        end else begin
                            bpx_next = item.init_pos_x;
                            bpy_next = item.init_pos_y;
                            bvx_next = item.init_vel_x;
                            bvy_next = item.init_vel_y;
                        end
                        state_next = tbgs_pkg::ST_OUT;
                    end else begin
                        dt_next    = item.time_step;
                        body_next  = tbgs_pkg::BODY_A;
                        state_next = tbgs_pkg::ST_OFF;
                    end
                end
            end
            tbgs_pkg::ST_OFF: begin
                offx_next   = magx;
                offy_next   = magy;
                negx_next   = dx[32];
                negy_next   = dy[32];
                sh_next     = sh_c;
                bx_next     = bxw[30:0];
                by_next     = byw[30:0];
                sq_cnt_next = '0;
                state_next  = tbgs_pkg::ST_SQ;
            end
            tbgs_pkg::ST_SQ: begin
                if (sq_cnt_reg == 3'd0) begin
                    sumsq_next = '0;
                end else if (sq_cnt_reg[0]) begin
                    sumsq_next = sumsq_reg + tbgs_pkg::sq_t'(prod_reg);
                end else begin
                    sumsq_next = sumsq_reg + (tbgs_pkg::sq_t'(prod_reg) << tbgs_pkg::HALF_W);
                end
                sq_cnt_next = sq_cnt_reg + 3'd1;
                if (sq_cnt_reg == 3'd4) begin
                    state_next = tbgs_pkg::ST_SQRT_GO;
                end
            end
            tbgs_pkg::ST_SQRT_GO: begin
                sq_start   = 1'b1;
                state_next = tbgs_pkg::ST_SQRT_W;
            end
            tbgs_pkg::ST_SQRT_W: begin
                if (sq_done) begin
                    d_next = (d_raw < tbgs_pkg::DIST_MIN) ? tbgs_pkg::DIST_MIN : d_raw;
                    state_next = tbgs_pkg::ST_GM;
                end
            end
            tbgs_pkg::ST_GM: begin
                state_next = tbgs_pkg::ST_D1;
            end
            tbgs_pkg::ST_D1: begin
                div_start  = 1'b1;
                div_num    = tbgs_pkg::num_t'(prod_reg[tbgs_pkg::GM_W-1:0])
                             << (2 * tbgs_pkg::FRAC_BITS);
                state_next = tbgs_pkg::ST_D1W;
            end
            tbgs_pkg::ST_D1W: begin
                if (div_done) begin
                    acc_next   = quo_cap;
                    state_next = tbgs_pkg::ST_D2;
                end
            end
            tbgs_pkg::ST_D2: begin
                div_start  = 1'b1;
                div_num    = tbgs_pkg::num_t'(acc_reg) << tbgs_pkg::FRAC_BITS;
                state_next = tbgs_pkg::ST_D2W;
            end
            tbgs_pkg::ST_D2W: begin
                if (div_done) begin
                    acc_next   = quo_cap;
                    axis_next  = 1'b0;
                    state_next = tbgs_pkg::ST_UD;
                end
            end
            tbgs_pkg::ST_UD: begin
                div_start  = 1'b1;
                div_num    = tbgs_pkg::num_t'(off_sel) << tbgs_pkg::FRAC_BITS;
                state_next = tbgs_pkg::ST_UDW;
            end
            tbgs_pkg::ST_UDW: begin
                if (div_done) begin
                    u_next = (div_quo > tbgs_pkg::num_t'(tbgs_pkg::U_ONE)) ? tbgs_pkg::U_ONE
                             : tbgs_pkg::unit_t'(div_quo);
                    state_next = tbgs_pkg::ST_T0;
                end
            end
            tbgs_pkg::ST_T0: begin
                state_next = tbgs_pkg::ST_T1;
            end
            tbgs_pkg::ST_T1: begin
                t_next     = tbgs_pkg::t_t'(prod_reg);
                state_next = tbgs_pkg::ST_T2;
            end
            tbgs_pkg::ST_T2: begin
                t_next     = t_reg + tbgs_pkg::t_t'(prod_reg >> tbgs_pkg::FRAC_BITS);
                state_next = tbgs_pkg::ST_T3;
            end
            tbgs_pkg::ST_T3: begin
                state_next = tbgs_pkg::ST_T4;
            end
            tbgs_pkg::ST_T4: begin
                case ({body_reg, axis_reg})
                    2'b00:   avx_next = new_v;
                    2'b01:   avy_next = new_v;
                    2'b10:   bvx_next = new_v;
                    default: bvy_next = new_v;
                endcase
                if (!axis_reg) begin
                    axis_next  = 1'b1;
                    state_next = tbgs_pkg::ST_UD;
                end else if (body_reg == tbgs_pkg::BODY_A) begin
                    body_next  = tbgs_pkg::BODY_B;
                    state_next = tbgs_pkg::ST_OFF;
                end else begin
                    crd_next   = 2'd0;
                    state_next = tbgs_pkg::ST_WRAP;
                end
            end
            tbgs_pkg::ST_WRAP: begin
                pw_next    = tbgs_pkg::sat_word(w2);
                state_next = tbgs_pkg::ST_MOVE;
            end
            tbgs_pkg::ST_MOVE: begin
                case (crd_reg)
                    2'd0:    apx_next = new_p;
                    2'd1:    apy_next = new_p;
                    2'd2:    bpx_next = new_p;
                    default: bpy_next = new_p;
                endcase
                if (crd_reg == 2'd3) begin
                    state_next = tbgs_pkg::ST_OUT;
                end else begin
                    crd_next   = crd_reg + 2'd1;
                    state_next = tbgs_pkg::ST_WRAP;
                end
            end
            tbgs_pkg::ST_OUT: begin
                result_valid = 1'b1;
                if (result_ready) begin
                    state_next = tbgs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tbgs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= tbgs_pkg::ST_IDLE;
            grav_reg   <= tbgs_pkg::RST_GRAVITY;
            mass_a_reg <= tbgs_pkg::RST_MASS_A;
            mass_b_reg <= tbgs_pkg::RST_MASS_B;
            rad_a_reg  <= tbgs_pkg::RST_RAD_A;
            rad_b_reg  <= tbgs_pkg::RST_RAD_B;
            fw_reg     <= tbgs_pkg::RST_FIELD_W;
            fh_reg     <= tbgs_pkg::RST_FIELD_H;
            apx_reg    <= '0;
            apy_reg    <= '0;
            avx_reg    <= '0;
            avy_reg    <= '0;
            bpx_reg    <= '0;
            bpy_reg    <= '0;
            bvx_reg    <= '0;
            bvy_reg    <= '0;
            body_reg   <= tbgs_pkg::BODY_A;
            axis_reg   <= 1'b0;
            crd_reg    <= '0;
            sq_cnt_reg <= '0;
        end else begin
            state_reg  <= state_next;
            grav_reg   <= grav_next;
            mass_a_reg <= mass_a_next;
            mass_b_reg <= mass_b_next;
            rad_a_reg  <= rad_a_next;
            rad_b_reg  <= rad_b_next;
            fw_reg     <= fw_next;
            fh_reg     <= fh_next;
            apx_reg    <= apx_next;
            apy_reg    <= apy_next;
            avx_reg    <= avx_next;
            avy_reg    <= avy_next;
            bpx_reg    <= bpx_next;
            bpy_reg    <= bpy_next;
            bvx_reg    <= bvx_next;
            bvy_reg    <= bvy_next;
            body_reg   <= body_next;
            axis_reg   <= axis_next;
            crd_reg    <= crd_next;
            sq_cnt_reg <= sq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg    <= dt_next;
        offx_reg  <= offx_next;
        offy_reg  <= offy_next;
        negx_reg  <= negx_next;
        negy_reg  <= negy_next;
        sh_reg    <= sh_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        sumsq_reg <= sumsq_next;
        prod_reg  <= prod_next;
        d_reg     <= d_next;
        acc_reg   <= acc_next;
        u_reg     <= u_next;
        t_reg     <= t_next;
        pw_reg    <= pw_next;
    end

    assign result.report_a_x  = apx_reg;
    assign result.report_a_y  = apy_reg;
    assign result.report_a_vx = avx_reg;
    assign result.report_a_vy = avy_reg;
    assign result.report_b_x  = bpx_reg;
    assign result.report_b_y  = bpy_reg;
    assign result.report_b_vx = bvx_reg;
    assign result.report_b_vy = bvy_reg;

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !item_ready)
        else $error("input taken while a result is pending");
    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.operation == tbgs_pkg::OP_LOAD |=> result_valid)
        else $error("load beat gave no result in the next cycle");
    a_dist_floor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tbgs_pkg::ST_D1 || state_reg == tbgs_pkg::ST_UD
        |-> d_reg >= tbgs_pkg::DIST_MIN)
        else $error("distance below floor entered the divider");
    a_unit_cap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tbgs_pkg::ST_T0 |-> u_reg <= tbgs_pkg::U_ONE)
        else $error("unit component above one");
`endif

endmodule
`default_nettype wire

/* tb/two_body_gravity_step_core_test.sv */
// Self-checking testbench of the two-body gravity step core with a built-in state predictor.
module two_body_gravity_step_core_test;

    localparam logic [tbgs_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int DRAIN_CYCLES = 800;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    tbgs_pkg::in_item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    tbgs_pkg::out_item_t result;
    logic wr_en = 1'b0;
    logic [tbgs_pkg::IDX_W-1:0] wr_index = '0;
    logic [tbgs_pkg::CFG_W-1:0] wr_data = '0;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int errors = 0;
    int cycles = 0;
    tbgs_pkg::out_item_t pending_reports[$];

    longint unsigned g_const, m_a, m_b, rad_a, rad_b, fld_w, fld_h;
    longint apx, apy, avx, avy, bpx, bpy, bvx, bvy;

    two_body_gravity_step_core dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned frac_div(input longint unsigned x,
                                                 input longint unsigned d);
        longint unsigned cap;
        longint unsigned hi;
        longint unsigned rem;
        longint unsigned q;
        cap = (64'd1 << 47) - 1;
        hi = x / d;
        rem = x % d;
        if (hi > (cap >> tbgs_pkg::FRAC_BITS))
            return cap;
        q = (hi << tbgs_pkg::FRAC_BITS) + ((rem << tbgs_pkg::FRAC_BITS) / d);
        return (q > cap) ? cap : q;
    endfunction

    function automatic longint dvel(input longint unsigned acc, input longint unsigned off,
                                    input longint unsigned d, input longint unsigned dt,
                                    input bit neg);
        longint unsigned one;
        longint unsigned u;
        longint unsigned t;
        longint unsigned dv;
        one = 64'd1 << tbgs_pkg::FRAC_BITS;
        u = (off << tbgs_pkg::FRAC_BITS) / d;
        if (u > one)
            u = one;
        t = (acc >> tbgs_pkg::FRAC_BITS) * u
            + (((acc & (one - 1)) * u) >> tbgs_pkg::FRAC_BITS);
        dv = (t * dt) >> tbgs_pkg::TS_BITS;
        return neg ? -longint'(dv) : longint'(dv);
    endfunction

    function automatic void pull_toward(input longint sx, input longint sy, input longint ox,
                                        input longint oy, input longint unsigned m_other,
                                        input longint unsigned dt, inout longint vx,
                                        inout longint vy);
        longint dx;
        longint dy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned bx;
        longint unsigned by;
        longint unsigned d;
        longint unsigned acc;
        int sh;
        dx = ox - sx;
        dy = oy - sy;
        ax = unsigned'((dx < 0) ? -dx : dx);
        ay = unsigned'((dy < 0) ? -dy : dy);
        bx = ax;
        by = ay;
        sh = 0;
        while (bx >= 64'h8000_0000 || by >= 64'h8000_0000)
        begin
            bx >>= 1;
            by >>= 1;
            sh++;
        end
        d = int_sqrt(bx * bx + by * by) << sh;
        if (d < 64'(tbgs_pkg::DIST_MIN))
            d = 64'(tbgs_pkg::DIST_MIN);
        acc = frac_div(frac_div((g_const * m_other) << tbgs_pkg::FRAC_BITS, d), d);
        vx = sat32(vx + dvel(acc, ax, d, dt, dx < 0));
        vy = sat32(vy + dvel(acc, ay, d, dt, dy < 0));
    endfunction

    function automatic longint wrap_edge(input longint p, input longint unsigned edge_px,
                                         input longint unsigned rad);
        longint lim;
        longint r;
        lim = longint'(edge_px << tbgs_pkg::FRAC_BITS);
        r = longint'(rad << tbgs_pkg::FRAC_BITS);
        if (p < -r)
            p = sat32(lim + r);
        if (p > lim + r)
            p = sat32(-r);
        return p;
    endfunction

    function automatic longint move_by(input longint p, input longint v,
                                       input longint unsigned dt);
        longint unsigned mag;
        mag = (unsigned'((v < 0) ? -v : v) * dt) >> tbgs_pkg::TS_BITS;
        return sat32((v < 0) ? p - longint'(mag) : p + longint'(mag));
    endfunction

    function automatic tbgs_pkg::out_item_t predict_report(input tbgs_pkg::in_item_t it);
        tbgs_pkg::out_item_t o;
        longint unsigned dt;
        if (it.operation == tbgs_pkg::OP_LOAD)
        begin
            if (it.body_select == tbgs_pkg::BODY_A)
            begin
                apx = longint'(signed'(it.init_pos_x));
                apy = longint'(signed'(it.init_pos_y));
                avx = longint'(signed'(it.init_vel_x));
                avy = longint'(signed'(it.init_vel_y));
            end
            else
            begin
                bpx = longint'(signed'(it.init_pos_x));
                bpy = longint'(signed'(it.init_pos_y));
                bvx = longint'(signed'(it.init_vel_x));
                bvy = longint'(signed'(it.init_vel_y));
            end
        end
        else
        begin
            dt = 64'(it.time_step);
            pull_toward(apx, apy, bpx, bpy, m_b, dt, avx, avy);
            pull_toward(bpx, bpy, apx, apy, m_a, dt, bvx, bvy);
            apx = move_by(wrap_edge(apx, fld_w, rad_a), avx, dt);
            apy = move_by(wrap_edge(apy, fld_h, rad_a), avy, dt);
            bpx = move_by(wrap_edge(bpx, fld_w, rad_b), bvx, dt);
            bpy = move_by(wrap_edge(bpy, fld_h, rad_b), bvy, dt);
        end
        o.report_a_x = apx[31:0]; o.report_a_y = apy[31:0];
        o.report_a_vx = avx[31:0]; o.report_a_vy = avy[31:0];
        o.report_b_x = bpx[31:0]; o.report_b_y = bpy[31:0];
        o.report_b_vx = bvx[31:0]; o.report_b_vy = bvy[31:0];
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge clk)
    begin
        tbgs_pkg::out_item_t exp_r;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result beat: expected none, actual %h", $time, result);
            end
            else
            begin
                exp_r = pending_reports.pop_front();
                check_field("report_a_x", exp_r.report_a_x, result.report_a_x);
                check_field("report_a_y", exp_r.report_a_y, result.report_a_y);
                check_field("report_a_vx", exp_r.report_a_vx, result.report_a_vx);
                check_field("report_a_vy", exp_r.report_a_vy, result.report_a_vy);
                check_field("report_b_x", exp_r.report_b_x, result.report_b_x);
                check_field("report_b_y", exp_r.report_b_y, result.report_b_y);
                check_field("report_b_vx", exp_r.report_b_vx, result.report_b_vx);
                check_field("report_b_vy", exp_r.report_b_vy, result.report_b_vy);
            end
        end
    end

    task automatic send_item(input tbgs_pkg::in_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item = it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pending_reports.push_back(predict_report(it));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tbgs_pkg::IDX_W-1:0] idx,
                             input logic [tbgs_pkg::CFG_W-1:0] val);
        @(negedge clk);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = val;
        @(negedge clk);
        wr_en = 1'b0;
        case (idx)
            tbgs_pkg::REG_GRAVITY: g_const = 64'(val[19:0]);
            tbgs_pkg::REG_MASS_A:  m_a = 64'(val[15:0]);
            tbgs_pkg::REG_MASS_B:  m_b = 64'(val[15:0]);
            tbgs_pkg::REG_RAD_A:   rad_a = 64'(val[9:0]);
            tbgs_pkg::REG_RAD_B:   rad_b = 64'(val[9:0]);
            tbgs_pkg::REG_FIELD_W: fld_w = 64'(val[11:0]);
            tbgs_pkg::REG_FIELD_H: fld_h = 64'(val[11:0]);
            default: ;
        endcase
    endtask

    function automatic tbgs_pkg::in_item_t noise_item();
        tbgs_pkg::in_item_t it;
        it.operation = 1'($urandom_range(1));
        it.body_select = 1'($urandom_range(1));
        it.init_pos_x = $urandom;
        it.init_pos_y = $urandom;
        it.init_vel_x = $urandom;
        it.init_vel_y = $urandom;
        it.time_step = 16'($urandom);
        return it;
    endfunction

    function automatic tbgs_pkg::in_item_t load_item(input logic body, input longint x,
                                                     input longint y, input longint vx,
                                                     input longint vy);
        tbgs_pkg::in_item_t it;
        it = noise_item();
        it.operation = tbgs_pkg::OP_LOAD;
        it.body_select = body;
        it.init_pos_x = x[31:0];
        it.init_pos_y = y[31:0];
        it.init_vel_x = vx[31:0];
        it.init_vel_y = vy[31:0];
        return it;
    endfunction

    function automatic tbgs_pkg::in_item_t step_item(input logic [15:0] dt);
        tbgs_pkg::in_item_t it;
        it = noise_item();
        it.operation = tbgs_pkg::OP_STEP;
        it.time_step = dt;
        return it;
    endfunction

    function automatic tbgs_pkg::in_item_t field_load(input logic body);
        longint span_x;
        longint span_y;
        span_x = longint'(fld_w + 1) << tbgs_pkg::FRAC_BITS;
        span_y = longint'(fld_h + 1) << tbgs_pkg::FRAC_BITS;
        return load_item(body,
                         longint'($urandom_range(span_x[31:0]))
                         - (64'sd40 << tbgs_pkg::FRAC_BITS),
                         longint'($urandom_range(span_y[31:0]))
                         - (64'sd40 << tbgs_pkg::FRAC_BITS),
                         longint'($urandom_range(400 << tbgs_pkg::FRAC_BITS))
                         - (64'sd200 << tbgs_pkg::FRAC_BITS),
                         longint'($urandom_range(400 << tbgs_pkg::FRAC_BITS))
                         - (64'sd200 << tbgs_pkg::FRAC_BITS));
    endfunction

    task automatic test_directed();
        send_item(step_item(16'hFFFF));
        send_item(load_item(tbgs_pkg::BODY_A, -(64'sd26 << tbgs_pkg::FRAC_BITS),
                            64'sd2147483647, 64'sd2147483647, -64'sd2147483648));
        send_item(load_item(tbgs_pkg::BODY_B, 64'sd2147483647, -64'sd2147483648, 0, 0));
        send_item(step_item(16'hFFFF));
        send_item(step_item(16'h0000));
        send_item(load_item(tbgs_pkg::BODY_A, 64'sd100 << tbgs_pkg::FRAC_BITS,
                            64'sd100 << tbgs_pkg::FRAC_BITS, 0, 0));
        send_item(load_item(tbgs_pkg::BODY_B, (64'sd100 << tbgs_pkg::FRAC_BITS) + 20,
                            64'sd100 << tbgs_pkg::FRAC_BITS, 0, 0));
        send_item(step_item(16'd1092));
        send_item(load_item(tbgs_pkg::BODY_A, 64'sd2000 << tbgs_pkg::FRAC_BITS,
                            -(64'sd30 << tbgs_pkg::FRAC_BITS),
                            64'sd50 << tbgs_pkg::FRAC_BITS,
                            -(64'sd50 << tbgs_pkg::FRAC_BITS)));
        send_item(load_item(tbgs_pkg::BODY_B, -(64'sd101 << tbgs_pkg::FRAC_BITS),
                            64'sd1181 << tbgs_pkg::FRAC_BITS,
                            -64'sd2147483648, 64'sd2147483647));
        send_item(step_item(16'd1092));
        send_item(step_item(16'hFFFF));
        send_item(load_item(tbgs_pkg::BODY_A, 64'sd500 << tbgs_pkg::FRAC_BITS,
                            64'sd500 << tbgs_pkg::FRAC_BITS, 0, 0));
        send_item(load_item(tbgs_pkg::BODY_B, 64'sd500 << tbgs_pkg::FRAC_BITS,
                            64'sd500 << tbgs_pkg::FRAC_BITS, 0, 0));
        send_item(step_item(16'd30000));
        send_item(noise_item());
        wait_drained();
    endtask

    task automatic test_register_extremes();
        write_reg(tbgs_pkg::REG_GRAVITY, 20'hFFFFF);
        write_reg(tbgs_pkg::REG_MASS_A, 20'hFFFFF);
        write_reg(tbgs_pkg::REG_MASS_B, 20'h0FFFF);
        write_reg(tbgs_pkg::REG_RAD_A, 20'hFFFFF);
        write_reg(tbgs_pkg::REG_RAD_B, 20'd0);
        write_reg(tbgs_pkg::REG_FIELD_W, 20'hFFFFF);
        write_reg(tbgs_pkg::REG_FIELD_H, 20'd0);
        write_reg(REG_UNUSED, 20'h12345);
        send_item(load_item(tbgs_pkg::BODY_A, 64'sd10, 64'sd10, 0, 0));
        send_item(load_item(tbgs_pkg::BODY_B, 64'sd300, -64'sd200, 0, 0));
        send_item(step_item(16'hFFFF));
        send_item(step_item(16'd1092));
        wait_drained();
        write_reg(tbgs_pkg::REG_GRAVITY, 20'd0);
        write_reg(tbgs_pkg::REG_MASS_A, 20'd0);
        write_reg(tbgs_pkg::REG_RAD_B, 20'd1023);
        write_reg(tbgs_pkg::REG_FIELD_W, 20'd1);
        write_reg(tbgs_pkg::REG_FIELD_H, 20'd4095);
        send_item(field_load(tbgs_pkg::BODY_B));
        send_item(step_item(16'hFFFF));
        send_item(step_item(16'd500));
        wait_drained();
    endtask

    task automatic random_config();
        write_reg(tbgs_pkg::REG_GRAVITY, ($urandom_range(3) == 0) ?
                  20'(tbgs_pkg::RST_GRAVITY) : 20'($urandom));
        write_reg(tbgs_pkg::REG_MASS_A, 20'($urandom_range(65535)));
        write_reg(tbgs_pkg::REG_MASS_B, 20'($urandom_range(65535)));
        write_reg(tbgs_pkg::REG_RAD_A, 20'($urandom_range(1023)));
        write_reg(tbgs_pkg::REG_RAD_B, 20'($urandom_range(1023)));
        write_reg(tbgs_pkg::REG_FIELD_W, 20'($urandom_range(1, 4095)));
        write_reg(tbgs_pkg::REG_FIELD_H, 20'($urandom_range(1, 4095)));
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int sent;
        int steps;
        logic [15:0] dt;
        src_idle_pct = idle_pct;
        snk_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_item(noise_item());
                sent++;
            end
            else
            begin
                send_item(field_load(tbgs_pkg::BODY_A));
                send_item(field_load(tbgs_pkg::BODY_B));
                steps = $urandom_range(2, 8);
                sent += 2 + steps;
                repeat (steps)
                begin
                    dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
                    send_item(step_item(dt));
                end
            end
            if ($urandom_range(19) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        g_const = 64'(tbgs_pkg::RST_GRAVITY);
        m_a = 64'(tbgs_pkg::RST_MASS_A);
        m_b = 64'(tbgs_pkg::RST_MASS_B);
        rad_a = 64'(tbgs_pkg::RST_RAD_A);
        rad_b = 64'(tbgs_pkg::RST_RAD_B);
        fld_w = 64'(tbgs_pkg::RST_FIELD_W);
        fld_h = 64'(tbgs_pkg::RST_FIELD_H);
        apx = 0; apy = 0; avx = 0; avy = 0; bpx = 0; bpy = 0; bvx = 0; bvy = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_register_extremes();
        random_config();
        write_reg(tbgs_pkg::REG_GRAVITY, tbgs_pkg::RST_GRAVITY);
        test_random_traffic(300, 0, 0);
        random_config();
        test_random_traffic(250, 88, 0);
        random_config();
        test_random_traffic(250, 0, 88);
        write_reg(tbgs_pkg::REG_GRAVITY, tbgs_pkg::RST_GRAVITY);
        write_reg(tbgs_pkg::REG_MASS_A, 20'(tbgs_pkg::RST_MASS_A));
        write_reg(tbgs_pkg::REG_MASS_B, 20'(tbgs_pkg::RST_MASS_B));
        test_random_traffic(250, 34, 34);
        snk_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
